// ===== src/pool_slot_allocator_rotating_hint_defines.svh =====
// Assertion macros for the slot pool allocator.
// Needs clk and arst_n in the scope of the module that expands them.
`ifndef POOL_SLOT_ALLOCATOR_ROTATING_HINT_DEFINES_SVH
`define POOL_SLOT_ALLOCATOR_ROTATING_HINT_DEFINES_SVH

// same-cycle implication
`define PSARH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PSARH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/psarh_pkg.sv =====
// Package for the slot pool allocator: transaction structs, command codes
// and parameter defaults. No dependencies.
package psarh_pkg;

	localparam int POOL_SLOTS_DEF = 32;
	localparam int COUNT_BITS_DEF = 32;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [4:0] slot_to_free;
		logic       release_overflow;
	} req_t;

	typedef struct packed {
		logic [4:0]  granted_slot;
		logic        granted_overflow;
		logic        double_free_error;
		logic [31:0] overflow_live;
		logic [31:0] overflow_peak;
		logic [31:0] overflow_total_allocs;
		logic [31:0] overflow_total_frees;
	} rsp_t;

endpackage

// ===== src/pool_slot_allocator_rotating_hint.sv =====
// Slot pool allocator with free bitmap, next-fit hint and overflow counters.
// Depends on psarh_pkg and pool_slot_allocator_rotating_hint_defines.svh.
// Free: result strobed in the cycle after start is accepted; the block is ready again at once.
// Allocate: one bitmap slot checked per cycle from the hint while busy, until a
// free one is granted; a full pool grants overflow after an extra peak update.
// Reset: every slot free, hint and all counters zero. done cannot be stalled.
`include "pool_slot_allocator_rotating_hint_defines.svh"

module pool_slot_allocator_rotating_hint #(
	parameter int POOL_SLOTS = psarh_pkg::POOL_SLOTS_DEF,
	parameter int COUNT_BITS = psarh_pkg::COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  psarh_pkg::req_t  req,
	output logic             done,
	output psarh_pkg::rsp_t  rsp
);

	localparam int IDX_W = (POOL_SLOTS > 2) ? $clog2(POOL_SLOTS) : 1;
	localparam int CMP_W = ((IDX_W > 5) ? IDX_W : 5) + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SLOTS - 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_PEAK = 2'd2;

	logic [1:0]            state_q;
	logic [POOL_SLOTS-1:0] free_map_q;
	logic [IDX_W-1:0]      hint_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      cnt_q;
	logic [COUNT_BITS-1:0] live_q;
	logic [COUNT_BITS-1:0] peak_q;
	logic [COUNT_BITS-1:0] alloc_q;
	logic [COUNT_BITS-1:0] frees_q;
	logic                  done_q;
	logic [4:0]            gslot_q;
	logic                  govf_q;
	logic                  dbl_q;

	logic                  accept;
	logic                  slot_ok;
	logic [IDX_W-1:0]      free_idx;
	logic [IDX_W-1:0]      idx_next;

	assign accept   = start && (state_q == ST_IDLE);
	assign slot_ok  = CMP_W'(req.slot_to_free) < CMP_W'(POOL_SLOTS);
	assign free_idx = IDX_W'(req.slot_to_free);
	assign idx_next = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			free_map_q <= '1;
			hint_q     <= '0;
			idx_q      <= '0;
			cnt_q      <= '0;
			live_q     <= '0;
			peak_q     <= '0;
			alloc_q    <= '0;
			frees_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.cmd == psarh_pkg::CMD_ALLOC) begin
							idx_q   <= hint_q;
							cnt_q   <= '0;
							state_q <= ST_SCAN;
						end else begin
							done_q <= 1'b1;
							if (req.release_overflow) begin
								if (live_q != '0) live_q <= live_q - 1'b1;
								if (frees_q != CNT_MAX) frees_q <= frees_q + 1'b1;
							end else if (slot_ok && !free_map_q[free_idx]) begin
								free_map_q[free_idx] <= 1'b1;
							end
						end
					end
				end
				ST_SCAN: begin
					if (free_map_q[idx_q]) begin
						free_map_q[idx_q] <= 1'b0;
						hint_q  <= idx_q;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (cnt_q == LAST_IDX) begin
						if (live_q != CNT_MAX) live_q <= live_q + 1'b1;
						if (alloc_q != CNT_MAX) alloc_q <= alloc_q + 1'b1;
						state_q <= ST_PEAK;
					end else begin
						idx_q <= idx_next;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_PEAK: begin
					if (live_q > peak_q) peak_q <= live_q;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result flags and slot index
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				gslot_q <= '0;
				govf_q  <= 1'b0;
				dbl_q   <= !req.release_overflow && slot_ok && free_map_q[free_idx];
			end
			ST_SCAN: begin
				gslot_q <= free_map_q[idx_q] ? 5'(idx_q) : 5'd0;
				govf_q  <= !free_map_q[idx_q];
				dbl_q   <= 1'b0;
			end
			default: begin
				gslot_q <= gslot_q;
				govf_q  <= govf_q;
				dbl_q   <= dbl_q;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	always_comb begin
		rsp.granted_slot          = gslot_q;
		rsp.granted_overflow      = govf_q;
		rsp.double_free_error     = dbl_q;
		rsp.overflow_live         = 32'(live_q);
		rsp.overflow_peak         = 32'(peak_q);
		rsp.overflow_total_allocs = 32'(alloc_q);
		rsp.overflow_total_frees  = 32'(frees_q);
	end

	`PSARH_ASSERT_NOW(a_done_idle, done, !busy, "result strobed while still busy")
	`PSARH_ASSERT_NEXT(a_alloc_busy, accept && (req.cmd == psarh_pkg::CMD_ALLOC), busy,
		"allocate accepted without starting a scan")
	`PSARH_ASSERT_NOW(a_ovf_full, done && rsp.granted_overflow, free_map_q == '0,
		"overflow granted while a pool slot is free")
	`PSARH_ASSERT_NOW(a_ovf_count, done && rsp.granted_overflow, rsp.overflow_total_allocs != '0,
		"overflow granted without counting it")

endmodule

// ===== sim/pool_slot_allocator_rotating_hint_test.sv =====
// Self-checking testbench for pool_slot_allocator_rotating_hint: directed table, then
// biased random fill/drain traffic, each response checked against the table or a bitmap/hint model.
// Depends on psarh_pkg and the RTL under src.
module pool_slot_allocator_rotating_hint_test;

	localparam int IDLE_LIMIT = 2000;
	localparam int RAND_ITEMS = 550;
	localparam int DRAIN_CYCLES = 40;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

	typedef struct {
		psarh_pkg::req_t stim;
		bit              typed;
		psarh_pkg::rsp_t want;
	} dir_row_t;

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	psarh_pkg::req_t req;
	logic            done;
	psarh_pkg::rsp_t rsp;

	bit [31:0]   slot_free = '1;
	logic [4:0]  hint = '0;
	logic [31:0] live_cnt = '0;
	logic [31:0] peak_cnt = '0;
	logic [31:0] ovf_allocs = '0;
	logic [31:0] ovf_frees = '0;

	psarh_pkg::rsp_t pending_rsp[$];
	dir_row_t        dir_tbl[$];
	int              err_count = 0;
	int              idle_cycles = 0;
	int              item_no = 0;

	pool_slot_allocator_rotating_hint u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic psarh_pkg::rsp_t mk_rsp(logic [4:0] slot, logic ovf, logic dbl,
			logic [31:0] live, logic [31:0] peak, logic [31:0] allocs, logic [31:0] frees);
		psarh_pkg::rsp_t o;
		o.granted_slot = slot;
		o.granted_overflow = ovf;
		o.double_free_error = dbl;
		o.overflow_live = live;
		o.overflow_peak = peak;
		o.overflow_total_allocs = allocs;
		o.overflow_total_frees = frees;
		return o;
	endfunction

	function automatic dir_row_t row(logic cmd, logic [4:0] slot, logic rel, bit typed,
			psarh_pkg::rsp_t want);
		dir_row_t d;
		d.stim.cmd = cmd;
		d.stim.slot_to_free = slot;
		d.stim.release_overflow = rel;
		d.typed = typed;
		d.want = want;
		return d;
	endfunction

	// next-fit pool model, one call per accepted transaction
	task automatic alloc_step(input psarh_pkg::req_t r, output psarh_pkg::rsp_t o);
		logic [4:0] idx;
		bit found;
		o = '0;
		found = 1'b0;
		if (r.cmd == psarh_pkg::CMD_ALLOC) begin
			idx = hint;
			repeat (32) begin
				if (!found && slot_free[idx]) begin
					found = 1'b1;
					slot_free[idx] = 1'b0;
					hint = idx;
					o.granted_slot = idx;
				end
				idx++;
			end
			if (!found) begin
				o.granted_overflow = 1'b1;
				if (live_cnt != '1) live_cnt++;
				if (ovf_allocs != '1) ovf_allocs++;
				if (live_cnt > peak_cnt) peak_cnt = live_cnt;
			end
		end else if (r.release_overflow) begin
			if (live_cnt != '0) live_cnt--;
			if (ovf_frees != '1) ovf_frees++;
		end else if (slot_free[r.slot_to_free]) begin
			o.double_free_error = 1'b1;
		end else begin
			slot_free[r.slot_to_free] = 1'b1;
		end
		o.overflow_live = live_cnt;
		o.overflow_peak = peak_cnt;
		o.overflow_total_allocs = ovf_allocs;
		o.overflow_total_frees = ovf_frees;
	endtask

	function automatic psarh_pkg::req_t next_req(mix_t mix);
		psarh_pkg::req_t r;
		int alloc_pct;
		logic [4:0] s;
		bit hit;
		r.cmd = 1'($urandom);
		r.slot_to_free = 5'($urandom);
		r.release_overflow = 1'($urandom);
		if ($urandom_range(0, 99) < 10) return r;
		case (mix)
			MIX_FILL: alloc_pct = 85;
			MIX_DRAIN: alloc_pct = 15;
			default: alloc_pct = 50;
		endcase
		if ($urandom_range(0, 99) < alloc_pct) begin
			r.cmd = psarh_pkg::CMD_ALLOC;
			return r;
		end
		r.cmd = psarh_pkg::CMD_FREE;
		if (live_cnt != '0 && $urandom_range(0, 3) == 0) begin
			r.release_overflow = 1'b1;
		end else begin
			r.release_overflow = 1'b0;
			s = 5'($urandom);
			hit = 1'b0;
			repeat (32) begin
				if (!hit) begin
					if (!slot_free[s]) begin
						hit = 1'b1;
						r.slot_to_free = s;
					end else begin
						s++;
					end
				end
			end
		end
		return r;
	endfunction

	// start stays high across back-to-back transactions
	task automatic send(psarh_pkg::req_t r, bit typed, psarh_pkg::rsp_t want);
		psarh_pkg::rsp_t pred;
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		alloc_step(r, pred);
		pending_rsp.push_back(typed ? want : pred);
		item_no++;
	endtask

	task automatic maybe_idle();
		if ((item_no < 250 || item_no >= 400) && $urandom_range(0, 99) < 7) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			err_count++;
		end
	endtask

	psarh_pkg::rsp_t head;

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %0h", $time, rsp);
				err_count++;
			end else begin
				head = pending_rsp.pop_front();
				check_field("granted_slot", 32'(head.granted_slot), 32'(rsp.granted_slot));
				check_field("granted_overflow", 32'(head.granted_overflow),
					32'(rsp.granted_overflow));
				check_field("double_free_error", 32'(head.double_free_error),
					32'(rsp.double_free_error));
				check_field("overflow_live", head.overflow_live, rsp.overflow_live);
				check_field("overflow_peak", head.overflow_peak, rsp.overflow_peak);
				check_field("overflow_total_allocs", head.overflow_total_allocs,
					rsp.overflow_total_allocs);
				check_field("overflow_total_frees", head.overflow_total_frees,
					rsp.overflow_total_frees);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;

		dir_tbl.push_back(row(psarh_pkg::CMD_ALLOC, 5'd31, 1'b1, 1'b1,
			mk_rsp(5'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0)));
		dir_tbl.push_back(row(psarh_pkg::CMD_ALLOC, 5'd0, 1'b0, 1'b1,
			mk_rsp(5'd1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0)));
		dir_tbl.push_back(row(psarh_pkg::CMD_FREE, 5'd0, 1'b0, 1'b1,
			mk_rsp(5'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0)));
		// double free of a released slot, then of a never-used top slot
		dir_tbl.push_back(row(psarh_pkg::CMD_FREE, 5'd0, 1'b0, 1'b1,
			mk_rsp(5'd0, 1'b0, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0)));
		dir_tbl.push_back(row(psarh_pkg::CMD_FREE, 5'd31, 1'b0, 1'b1,
			mk_rsp(5'd0, 1'b0, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0)));
		// overflow free with nothing outstanding
		dir_tbl.push_back(row(psarh_pkg::CMD_FREE, 5'd31, 1'b1, 1'b1,
			mk_rsp(5'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd1)));
		dir_tbl.push_back(row(psarh_pkg::CMD_ALLOC, 5'd0, 1'b0, 1'b0, '0));
		dir_tbl.push_back(row(psarh_pkg::CMD_ALLOC, 5'd31, 1'b0, 1'b0, '0));
		dir_tbl.push_back(row(psarh_pkg::CMD_FREE, 5'd2, 1'b0, 1'b0, '0));
		dir_tbl.push_back(row(psarh_pkg::CMD_ALLOC, 5'd0, 1'b1, 1'b0, '0));
		dir_tbl.push_back(row(psarh_pkg::CMD_FREE, 5'd1, 1'b0, 1'b0, '0));
		dir_tbl.push_back(row(psarh_pkg::CMD_FREE, 5'd3, 1'b0, 1'b0, '0));
		dir_tbl.push_back(row(psarh_pkg::CMD_FREE, 5'd0, 1'b1, 1'b0, '0));
		dir_tbl.push_back(row(psarh_pkg::CMD_FREE, 5'd4, 1'b0, 1'b0, '0));
		dir_tbl.push_back(row(psarh_pkg::CMD_ALLOC, 5'd31, 1'b1, 1'b0, '0));
		dir_tbl.push_back(row(psarh_pkg::CMD_FREE, 5'd31, 1'b0, 1'b0, '0));
		dir_tbl.push_back(row(psarh_pkg::CMD_FREE, 5'd4, 1'b0, 1'b0, '0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tbl[i]) begin
			send(dir_tbl[i].stim, dir_tbl[i].typed, dir_tbl[i].want);
			maybe_idle();
		end

		for (int k = 0; k < RAND_ITEMS; k++) begin
			send(next_req(mix_t'((k / 50) % 3)), 1'b0, '0);
			maybe_idle();
		end

		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+src
src/psarh_pkg.sv
src/pool_slot_allocator_rotating_hint.sv
sim/pool_slot_allocator_rotating_hint_test.sv
